>>> design/dram_traffic_burst_monitor_unit_defines.svh
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - assertion macros
// Shared concurrent assertion forms used by the monitor's modules.
// ----------------------------------------------------------------------------
`ifndef DRAM_TRAFFIC_BURST_MONITOR_UNIT_DEFINES_SVH
`define DRAM_TRAFFIC_BURST_MONITOR_UNIT_DEFINES_SVH

// condition holds on every clock edge outside reset
`define DTBM_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define DTBM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTBM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/dtbm_pkg.sv
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - package
// Types, codes and helpers shared by the monitor's front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package dtbm_pkg;

  localparam int NUM_REQUESTERS = 10;
  localparam int ROW_IDX_W      = $clog2(NUM_REQUESTERS);
  localparam int CLIENT_W       = 4;
  localparam int ADDR_W         = 32;
  localparam int LEN_W          = 16;
  localparam int MEM_W          = 33;
  localparam int SHIFT_W        = 4;
  localparam int CNT_W          = 64;
  localparam int MAX_SHIFT      = 12;
  // offset inside a burst plus length, minus one, shifted, plus one
  localparam int BURSTS_W       = LEN_W + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CLIENT_W-1:0] TOTAL_ROW = CLIENT_W'(NUM_REQUESTERS);

  localparam logic [1:0] CMD_ACCESS = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_RANGE  = 2'd1;
  localparam logic [1:0] ERR_CLIENT = 2'd2;

  localparam logic REG_BURST_SHIFT  = 1'b0;
  localparam logic REG_MEMORY_BYTES = 1'b1;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET  = SHIFT_W'(6);
  localparam logic [MEM_W-1:0]   MEMORY_RESET = MEM_W'(64'h1_0000_0000);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ACCESS,
    OP_QUERY,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [1:0]          command;
    logic                is_write;
    logic [ADDR_W-1:0]   address;
    logic [LEN_W-1:0]    length;
    logic [CLIENT_W-1:0] client;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       error;
    logic [CNT_W-1:0] read_count;
    logic [CNT_W-1:0] write_count;
    logic [CNT_W-1:0] rd_byte_total;
    logic [CNT_W-1:0] wr_byte_total;
    logic [CNT_W-1:0] rd_burst_total;
    logic [CNT_W-1:0] wr_burst_total;
    logic [CNT_W-1:0] moved_bytes;
  } out_item_t;

  // classified work handed from front to back
  typedef struct packed {
    op_t                 op;
    logic [1:0]          error;
    logic                is_write;
    logic [CLIENT_W-1:0] row;
    logic [LEN_W-1:0]    length;
    logic [BURSTS_W-1:0] bursts;
  } work_t;

  typedef struct packed {
    logic [CNT_W-1:0] rd_cnt;
    logic [CNT_W-1:0] wr_cnt;
    logic [CNT_W-1:0] rd_bytes;
    logic [CNT_W-1:0] wr_bytes;
    logic [CNT_W-1:0] rd_bursts;
    logic [CNT_W-1:0] wr_bursts;
  } row_t;

  // burst_shift holds the saturated shift
  typedef struct packed {
    logic [SHIFT_W-1:0] burst_shift;
    logic [MEM_W-1:0]   memory_bytes;
  } cfg_t;

  function automatic row_t row_add(row_t r, logic wr, logic [LEN_W-1:0] len,
                                   logic [BURSTS_W-1:0] bursts);
    row_t n;
    n = r;
    if (wr) begin
      n.wr_cnt    = r.wr_cnt + CNT_W'(1);
      n.wr_bytes  = r.wr_bytes + CNT_W'(len);
      n.wr_bursts = r.wr_bursts + CNT_W'(bursts);
    end else begin
      n.rd_cnt    = r.rd_cnt + CNT_W'(1);
      n.rd_bytes  = r.rd_bytes + CNT_W'(len);
      n.rd_bursts = r.rd_bursts + CNT_W'(bursts);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> design/dram_traffic_burst_monitor_unit.sv
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - top level
// Per-client memory traffic counters with bounds check and burst accounting.
// ----------------------------------------------------------------------------
// Every item (access, query, clear) gives exactly one result. The block takes
// one item per cycle sustained while out_stall stays low; an item passes the
// front classification register and the two-entry work queue before its
// result reaches the result register. The single counter update in the back
// end, a 64-bit add on the client row and the total row, sets that rate.
// Counters are cleared by reset and by the clear command. Write burst_shift
// and memory_bytes only while no item is in flight; cfg_ready is always high.
`default_nettype none

module dram_traffic_burst_monitor_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire dtbm_pkg::in_item_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output dtbm_pkg::out_item_t                   out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [dtbm_pkg::MEM_W-1:0]       cfg_data
);
  import dtbm_pkg::*;

  cfg_t  cfg;
  logic  work_valid;
  work_t work;
  logic  work_full;
  logic  q_not_empty;
  work_t q_head;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  // shift saturates at write, it is never read back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.burst_shift  <= SHIFT_RESET;
      cfg.memory_bytes <= MEMORY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BURST_SHIFT: begin
          cfg.burst_shift <= (cfg_data[SHIFT_W-1:0] > SHIFT_W'(MAX_SHIFT))
                           ? SHIFT_W'(MAX_SHIFT) : cfg_data[SHIFT_W-1:0];
        end
        REG_MEMORY_BYTES: begin
          cfg.memory_bytes <= cfg_data;
        end
      endcase
    end
  end

  dtbm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .work_valid (work_valid),
    .work       (work),
    .work_full  (work_full)
  );

  dtbm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (work_valid),
    .push_data (work),
    .full      (work_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  dtbm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_ready (q_not_empty),
    .work       (q_head),
    .work_pop   (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

>>> design/dtbm_front.sv
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - front end
// Accepts items, bounds-checks accesses, counts spanned bursts and registers
// the classified work for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtbm_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dtbm_pkg::cfg_t    cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire dtbm_pkg::in_item_t in_data,
  output logic                   work_valid,
  output dtbm_pkg::work_t        work,
  input  wire logic              work_full
);
  import dtbm_pkg::*;

  logic [MEM_W-1:0]    span_end;
  logic                past_end;
  logic [11:0]         low_mask;
  logic [BURSTS_W-1:0] end_off;
  logic [BURSTS_W-1:0] bursts;
  work_t               work_next;

  assign in_stall = work_valid && work_full;

  // exact end of access, 33 bits cannot overflow
  assign span_end = {1'b0, in_data.address} + MEM_W'(in_data.length);
  assign past_end = span_end > cfg.memory_bytes;

  // bursts = ((addr mod burst) + len - 1) >> shift, plus one; zero when len is zero
  assign low_mask = ~(12'hFFF << cfg.burst_shift);
  assign end_off  = BURSTS_W'(in_data.address[11:0] & low_mask)
                  + BURSTS_W'(in_data.length) - BURSTS_W'(1);
  assign bursts   = (in_data.length == '0) ? '0
                  : (end_off >> cfg.burst_shift) + BURSTS_W'(1);

  always_comb begin
    work_next          = '0;
    work_next.op       = OP_NONE;
    work_next.error    = ERR_OK;
    work_next.is_write = in_data.is_write;
    work_next.row      = in_data.client;
    work_next.length   = in_data.length;
    work_next.bursts   = bursts;
    unique case (in_data.command)
      CMD_ACCESS: begin
        if (past_end) begin
          work_next.error = ERR_RANGE;
        end else if ({1'b0, in_data.client} >= (CLIENT_W + 1)'(NUM_REQUESTERS)) begin
          work_next.error = ERR_CLIENT;
        end else begin
          work_next.op = OP_ACCESS;
        end
      end
      CMD_QUERY: begin
        if ({1'b0, in_data.client} > (CLIENT_W + 1)'(NUM_REQUESTERS)) begin
          work_next.error = ERR_CLIENT;
        end else begin
          work_next.op = OP_QUERY;
        end
      end
      CMD_CLEAR: begin
        work_next.op = OP_CLEAR;
      end
      default: begin
        work_next.op = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (!in_stall) begin
      work_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

>>> design/dtbm_queue.sv
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - work queue
// Short FIFO between front and back so each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dram_traffic_burst_monitor_unit_defines.svh"

module dtbm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dtbm_pkg::work_t push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output dtbm_pkg::work_t      head
);
  import dtbm_pkg::*;

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `DTBM_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= QCNT_W'(QUEUE_DEPTH), "queue count over depth")
  `DTBM_ASSERT_IMPL(a_no_pop_empty, clk, rst, pop, count != '0, "pop from empty queue")

endmodule

`default_nettype wire

>>> design/dtbm_back.sv
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - back end
// Holds the per-client and total counter rows, applies accesses and clears,
// answers queries and keeps the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dram_traffic_burst_monitor_unit_defines.svh"

module dtbm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dtbm_pkg::cfg_t   cfg,
  input  wire logic             work_ready,
  input  wire dtbm_pkg::work_t  work,
  output logic                  work_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output dtbm_pkg::out_item_t   out_data
);
  import dtbm_pkg::*;

  row_t      client_rows [NUM_REQUESTERS];
  row_t      total;
  row_t      cur;
  row_t      client_next;
  row_t      total_next;
  out_item_t result;
  logic      is_total;

  assign work_pop = work_ready && (!out_valid || !out_stall);

  assign is_total    = work.row == TOTAL_ROW;
  assign cur         = is_total ? total : client_rows[work.row[ROW_IDX_W-1:0]];
  assign client_next = row_add(cur, work.is_write, work.length, work.bursts);
  assign total_next  = row_add(total, work.is_write, work.length, work.bursts);

  always_comb begin
    result       = '0;
    result.error = work.error;
    if (work.op == OP_QUERY) begin
      result.read_count     = cur.rd_cnt;
      result.write_count    = cur.wr_cnt;
      result.rd_byte_total  = cur.rd_bytes;
      result.wr_byte_total  = cur.wr_bytes;
      result.rd_burst_total = cur.rd_bursts;
      result.wr_burst_total = cur.wr_bursts;
      result.moved_bytes    = (cur.rd_bursts + cur.wr_bursts) << cfg.burst_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
        client_rows[i] <= '0;
      end
      total <= '0;
    end else if (work_pop) begin
      unique case (work.op)
        OP_ACCESS: begin
          client_rows[work.row[ROW_IDX_W-1:0]] <= client_next;
          total <= total_next;
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_REQUESTERS; i++) begin
            client_rows[i] <= '0;
          end
          total <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (work_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (work_pop) begin
      out_data <= result;
    end
  end

  `DTBM_ASSERT_NEXT(a_clear_total, clk, rst, work_pop && work.op == OP_CLEAR, total == '0, "total row not cleared")
  `DTBM_ASSERT_NEXT(a_access_count, clk, rst, work_pop && work.op == OP_ACCESS, CNT_W'(total.rd_cnt + total.wr_cnt) == CNT_W'($past(total.rd_cnt + total.wr_cnt) + 1), "total access count not bumped")
  `DTBM_ASSERT_IMPL(a_err_no_data, clk, rst, out_valid && out_data.error != ERR_OK, out_data.read_count == '0 && out_data.moved_bytes == '0, "error result carries counters")

endmodule

`default_nettype wire

>>> verif/tb_dram_traffic_burst_monitor_unit.sv
// ----------------------------------------------------------------------------
// DRAM traffic burst monitor - testbench
// Directed table then random traffic over several register settings; every
// result is checked per field against the table or an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_dram_traffic_burst_monitor_unit;
  import dtbm_pkg::*;

  localparam int ROWS        = NUM_REQUESTERS + 1;
  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_PHASES  = 7;
  localparam logic [MEM_W-1:0] MEM_4G = MEM_W'(64'h1_0000_0000);
  // command code with no function
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = REG_BURST_SHIFT;
  logic [MEM_W-1:0] cfg_data = '0;

  // predictor state
  logic [CNT_W-1:0]   rd_cnt [ROWS];
  logic [CNT_W-1:0]   wr_cnt [ROWS];
  logic [CNT_W-1:0]   rd_byt [ROWS];
  logic [CNT_W-1:0]   wr_byt [ROWS];
  logic [CNT_W-1:0]   rd_bst [ROWS];
  logic [CNT_W-1:0]   wr_bst [ROWS];
  logic [SHIFT_W-1:0] shift_eff = SHIFT_RESET;
  logic [MEM_W-1:0]   mem_size  = MEMORY_RESET;

  out_item_t pending_reports[$];
  dir_row_t  directed_rows[$];
  int        fails  = 0;
  int        cycles = 0;
  bit        quiet  = 1'b0;
  int        stall_left = 0;

  dram_traffic_burst_monitor_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_dram_traffic_burst_monitor_unit: FAIL");
      $finish;
    end
  end

  // receiver backpressure in short bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_stall = 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall = 1'b0;
    end
  end

  function automatic void zero_rows();
    for (int r = 0; r < ROWS; r++) begin
      rd_cnt[r] = '0; wr_cnt[r] = '0;
      rd_byt[r] = '0; wr_byt[r] = '0;
      rd_bst[r] = '0; wr_bst[r] = '0;
    end
  endfunction

  function automatic void bump_row(int r, logic wr, logic [CNT_W-1:0] len,
                                   logic [CNT_W-1:0] bursts);
    if (wr) begin
      wr_cnt[r] += CNT_W'(1); wr_byt[r] += len; wr_bst[r] += bursts;
    end else begin
      rd_cnt[r] += CNT_W'(1); rd_byt[r] += len; rd_bst[r] += bursts;
    end
  endfunction

  // advance the counter model by one item and return its report
  function automatic out_item_t tally_item(in_item_t it);
    out_item_t        res;
    logic [CNT_W-1:0] a64;
    logic [CNT_W-1:0] len64;
    logic [CNT_W-1:0] bursts;
    int               r;
    res   = '0;
    a64   = CNT_W'(it.address);
    len64 = CNT_W'(it.length);
    case (it.command)
      CMD_ACCESS: begin
        if (a64 + len64 > CNT_W'(mem_size)) begin
          res.error = ERR_RANGE;
        end else if (it.client >= CLIENT_W'(NUM_REQUESTERS)) begin
          res.error = ERR_CLIENT;
        end else begin
          bursts = (len64 == '0) ? '0 :
                   ((a64 + len64 - CNT_W'(1)) >> shift_eff) - (a64 >> shift_eff)
                   + CNT_W'(1);
          bump_row(int'(it.client), it.is_write, len64, bursts);
          bump_row(NUM_REQUESTERS, it.is_write, len64, bursts);
        end
      end
      CMD_QUERY: begin
        if (it.client > TOTAL_ROW) begin
          res.error = ERR_CLIENT;
        end else begin
          r = int'(it.client);
          res.read_count     = rd_cnt[r];
          res.write_count    = wr_cnt[r];
          res.rd_byte_total  = rd_byt[r];
          res.wr_byte_total  = wr_byt[r];
          res.rd_burst_total = rd_bst[r];
          res.wr_burst_total = wr_bst[r];
          res.moved_bytes    = (rd_bst[r] + wr_bst[r]) << shift_eff;
        end
      end
      CMD_CLEAR: zero_rows();
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t mk(logic [1:0] cmd, logic wr, logic [ADDR_W-1:0] addr,
                                  logic [LEN_W-1:0] len, logic [CLIENT_W-1:0] client);
    in_item_t it;
    it.command  = cmd;
    it.is_write = wr;
    it.address  = addr;
    it.length   = len;
    it.client   = client;
    return it;
  endfunction

  function automatic dir_row_t row(in_item_t it, bit typed, logic [1:0] err);
    dir_row_t d;
    d.item       = it;
    d.typed      = typed;
    d.want       = '0;
    d.want.error = err;
    return d;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t         it;
    int               pick;
    int               mode;
    logic [CNT_W-1:0] lim;
    it          = '0;
    it.address  = $urandom;
    it.length   = LEN_W'($urandom);
    it.client   = CLIENT_W'($urandom);
    it.is_write = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      it.command = CMD_ACCESS;
      it.client  = ($urandom_range(0, 9) != 0)
                 ? CLIENT_W'($urandom_range(0, NUM_REQUESTERS - 1))
                 : CLIENT_W'($urandom_range(NUM_REQUESTERS, 15));
      case ($urandom_range(0, 7))
        0:       it.length = '0;
        1:       it.length = '1;
        2, 3:    it.length = LEN_W'($urandom);
        default: it.length = LEN_W'($urandom_range(1, 300));
      endcase
      mode = $urandom_range(0, 9);
      if (mode < 7 && CNT_W'(mem_size) >= CNT_W'(it.length)) begin
        lim = CNT_W'(mem_size) - CNT_W'(it.length);
        if (lim > 64'hFFFF_FFFF) lim = 64'hFFFF_FFFF;
        case (mode)
          0:       it.address = ADDR_W'(lim);
          1:       it.address = '0;
          default: it.address = ADDR_W'({32'h0, $urandom} % (lim + CNT_W'(1)));
        endcase
      end
    end else if (pick < 95) begin
      it.command = CMD_QUERY;
      it.client  = ($urandom_range(0, 9) != 0)
                 ? CLIENT_W'($urandom_range(0, NUM_REQUESTERS))
                 : CLIENT_W'($urandom_range(NUM_REQUESTERS + 1, 15));
    end else if (pick < 97) begin
      it.command = CMD_CLEAR;
    end else begin
      it.command = CMD_UNUSED;  // must be ignored
    end
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t got;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    got = tally_item(it);
    pending_reports.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [MEM_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BURST_SHIFT)
      shift_eff = (val[SHIFT_W-1:0] > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT)
                                                          : val[SHIFT_W-1:0];
    else
      mem_size = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cmp_field(input string name, input logic [CNT_W-1:0] e,
                           input logic [CNT_W-1:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual %0h", $time, out_data);
        fails++;
      end else begin
        want = pending_reports.pop_front();
        cmp_field("error", CNT_W'(want.error), CNT_W'(out_data.error));
        cmp_field("read_count", want.read_count, out_data.read_count);
        cmp_field("write_count", want.write_count, out_data.write_count);
        cmp_field("rd_byte_total", want.rd_byte_total, out_data.rd_byte_total);
        cmp_field("wr_byte_total", want.wr_byte_total, out_data.wr_byte_total);
        cmp_field("rd_burst_total", want.rd_burst_total, out_data.rd_burst_total);
        cmp_field("wr_burst_total", want.wr_burst_total, out_data.wr_burst_total);
        cmp_field("moved_bytes", want.moved_bytes, out_data.moved_bytes);
      end
    end
  end

  initial begin
    logic [SHIFT_W-1:0] ph_shift [NUM_PHASES];
    logic [MEM_W-1:0]   ph_mem   [NUM_PHASES];
    zero_rows();
    ph_shift = '{4'd0, 4'd12, 4'd15, 4'd3, 4'd13, 4'd9, 4'd6};
    ph_mem   = '{MEM_4G, MEM_W'(1 << 20), MEM_W'(4096), MEM_W'(0), MEM_W'(1),
                 MEM_W'(64'h8000_0000), MEM_4G};

    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, 4'd0), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, TOTAL_ROW), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, 4'd11), 1'b1, ERR_CLIENT));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b1, '1, '1, 4'd15), 1'b1, ERR_CLIENT));
    // top byte of memory is in range, one past it is not
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b0, '1, 16'd1, 4'd0), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b1, '1, 16'd2, 4'd9), 1'b1, ERR_RANGE));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b1, '0, '1, 4'd9), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b0, 32'h3F, 16'd2, 4'd1), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b0, 32'h100, 16'd0, 4'd2), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b1, 32'h40, 16'd1, TOTAL_ROW), 1'b1,
                                ERR_CLIENT));
    // range check wins over bad client
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b1, '1, '1, 4'd15), 1'b1, ERR_RANGE));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b1, '0, '0, 4'd15), 1'b1, ERR_CLIENT));
    directed_rows.push_back(row(mk(CMD_UNUSED, 1'b1, '1, '1, 4'd15), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, 4'd0), 1'b0, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, 4'd1), 1'b0, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, 4'd9), 1'b0, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, TOTAL_ROW), 1'b0, ERR_OK));
    directed_rows.push_back(row(mk(CMD_CLEAR, 1'b1, '1, '1, '1), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, TOTAL_ROW), 1'b1, ERR_OK));
    directed_rows.push_back(row(mk(CMD_ACCESS, 1'b1, 32'hFFFF_0000, '1, 4'd5), 1'b1,
                                ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, 4'd5), 1'b0, ERR_OK));
    directed_rows.push_back(row(mk(CMD_QUERY, 1'b0, '0, '0, TOTAL_ROW), 1'b0, ERR_OK));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      push_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_BURST_SHIFT, MEM_W'(ph_shift[p]));
      write_reg(REG_MEMORY_BYTES, ph_mem[p]);
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      repeat (PHASE_ITEMS) push_item(rand_item(), 1'b0, '0);
      // zero-memory setting: only an empty access at address zero passes
      if (ph_mem[p] == '0) begin
        push_item(mk(CMD_ACCESS, 1'b0, '0, '0, 4'd3), 1'b0, '0);
        push_item(mk(CMD_ACCESS, 1'b0, 32'd1, '0, 4'd3), 1'b0, '0);
        push_item(mk(CMD_ACCESS, 1'b1, '0, 16'd1, 4'd3), 1'b0, '0);
      end
      push_item(mk(CMD_QUERY, 1'b0, '0, '0, TOTAL_ROW), 1'b0, '0);
    end
    drain();

    if (fails == 0) begin
      $display("tb_dram_traffic_burst_monitor_unit: PASS");
    end else begin
      $display("tb_dram_traffic_burst_monitor_unit: FAIL");
    end
    $finish;
  end

endmodule
